>>> sv/adaptive_non_maximal_suppression_macros.svh
// assertion macros for the anms checker
`ifndef ADAPTIVE_NON_MAXIMAL_SUPPRESSION_MACROS_SVH
`define ADAPTIVE_NON_MAXIMAL_SUPPRESSION_MACROS_SVH
// implication checked at every clock edge outside reset
`define ANMS_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("implication failed");
// condition that must hold at every clock edge outside reset
`define ANMS_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("invariant failed");
`endif

>>> sv/anms_pkg.sv
// shared types and constants of the anms block
package anms_pkg;
    localparam int RADIUS_BITS = 26;
    localparam logic [RADIUS_BITS-1:0] RADIUS_INF = '1;
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_TO_KEEP  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROBUST_COEFF = 1'b1;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SORT,
        BK_RAD,
        BK_THR,
        BK_EMIT
    } bk_state_t;
endpackage

>>> sv/anms_ram.sv
// generic single write, single registered read ram
module anms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/anms_front.sv
// input side: skid queue of accepted points
module anms_front #(
    parameter int COORD_BITS    = 12,
    parameter int RESPONSE_BITS = 16,
    parameter int QW            = 2*COORD_BITS + RESPONSE_BITS + 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [QW-1:0] in_data,
    output logic          q_valid,
    input  logic          q_ready,
    output logic [QW-1:0] q_data
);
    // two-entry queue
    logic [QW-1:0] buf_reg [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          rd_reg, rd_next;
    logic          push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = buf_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        rd_next  = pop ? ~rd_reg : rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
        if (push) begin
            buf_reg[rd_reg ^ cnt_reg[0]] <= in_data;
        end
    end
endmodule

>>> sv/anms_back.sv
// selection engine: load, rank sort, radius search, threshold and emit
module anms_back #(
    parameter int MAX_POINTS    = 64,
    parameter int COORD_BITS    = 12,
    parameter int RESPONSE_BITS = 16,
    parameter int QW            = 2*COORD_BITS + RESPONSE_BITS + 1,
    parameter int OW            = 2*COORD_BITS + RESPONSE_BITS + anms_pkg::RADIUS_BITS + 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  logic [QW-1:0] q_data,
    input  logic [6:0]    num_to_keep,
    input  logic [8:0]    robust_coeff,
    output logic          o_valid,
    input  logic          o_ready,
    output logic [OW-1:0] o_data
);
    import anms_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;
    localparam int PW = 2*COORD_BITS + RESPONSE_BITS;
    localparam int DW = 2*COORD_BITS + 1;
    localparam int XW = (DW > RADIUS_BITS) ? DW : RADIUS_BITS;
    localparam int MW = RESPONSE_BITS + 9;
    localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

    bk_state_t     st_reg, st_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] tot_reg, tot_next, k_reg, k_next;
    logic [RADIUS_BITS-1:0] r_reg, r_next, thr_reg, thr_next;
    logic          small_reg, small_next;
    logic          o_valid_reg, o_valid_next;
    logic [OW-1:0] o_data_reg, o_data_next;

    // port a reads entry i, port b reads entry j of every store
    logic [AW-1:0] addr_a, addr_b;
    logic          pt_we, srt_we, rad_we;
    logic [PW-1:0] pt_a_rd, pt_b_rd, srt_a_rd, srt_b_rd;
    logic [RADIUS_BITS-1:0] rad_a_rd, rad_b_rd;

    logic          q_last;
    logic          take;
    logic          hit;
    logic          ahead;
    logic [CW-1:0] cnt_add;
    logic [CW-1:0] jm1;
    logic [RESPONSE_BITS-1:0] resp_pi, resp_pj, resp_si, resp_sj;
    logic [MW-1:0] own_p, nb_p;
    logic [COORD_BITS-1:0] dx, dy;
    logic [DW-1:0] dsq;
    logic [RADIUS_BITS-1:0] dsat, r_upd;

    assign addr_a = i_reg[AW-1:0];
    assign addr_b = j_reg[AW-1:0];

    // points in load order
    anms_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pt_a (
        .aclk(aclk), .we(pt_we), .waddr(n_reg[AW-1:0]), .wdata(q_data[PW-1:0]),
        .raddr(addr_a), .rdata(pt_a_rd)
    );
    anms_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pt_b (
        .aclk(aclk), .we(pt_we), .waddr(n_reg[AW-1:0]), .wdata(q_data[PW-1:0]),
        .raddr(addr_b), .rdata(pt_b_rd)
    );
    // points by descending response
    anms_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_srt_a (
        .aclk(aclk), .we(srt_we), .waddr(cnt_add[AW-1:0]), .wdata(pt_a_rd),
        .raddr(addr_a), .rdata(srt_a_rd)
    );
    anms_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_srt_b (
        .aclk(aclk), .we(srt_we), .waddr(cnt_add[AW-1:0]), .wdata(pt_a_rd),
        .raddr(addr_b), .rdata(srt_b_rd)
    );
    // radius of each sorted point
    anms_ram #(.WIDTH(RADIUS_BITS), .DEPTH(MAX_POINTS)) u_rad_a (
        .aclk(aclk), .we(rad_we), .waddr(i_reg[AW-1:0]), .wdata(r_upd),
        .raddr(addr_a), .rdata(rad_a_rd)
    );
    anms_ram #(.WIDTH(RADIUS_BITS), .DEPTH(MAX_POINTS)) u_rad_b (
        .aclk(aclk), .we(rad_we), .waddr(i_reg[AW-1:0]), .wdata(r_upd),
        .raddr(addr_b), .rdata(rad_b_rd)
    );

    assign q_last  = q_data[QW-1];
    assign q_ready = (st_reg == BK_IDLE);
    assign take    = q_valid && q_ready;
    assign o_valid = o_valid_reg;
    assign o_data  = o_data_reg;

    // data on port b belongs to entry j-1 (the read is registered)
    assign jm1     = j_reg - CW'(1);
    assign resp_pi = pt_a_rd[PW-1 -: RESPONSE_BITS];
    assign resp_pj = pt_b_rd[PW-1 -: RESPONSE_BITS];
    assign resp_si = srt_a_rd[PW-1 -: RESPONSE_BITS];
    assign resp_sj = srt_b_rd[PW-1 -: RESPONSE_BITS];
    // stable descending rank: stronger points, or equal ones loaded earlier
    assign ahead = (resp_pj > resp_pi) || ((resp_pj == resp_pi) && (jm1 < i_reg));

    assign own_p = MW'(resp_si) * MW'(robust_coeff);
    assign nb_p  = {1'b0, resp_sj, 8'd0};
    assign dx = (srt_a_rd[COORD_BITS-1:0] > srt_b_rd[COORD_BITS-1:0])
              ? srt_a_rd[COORD_BITS-1:0] - srt_b_rd[COORD_BITS-1:0]
              : srt_b_rd[COORD_BITS-1:0] - srt_a_rd[COORD_BITS-1:0];
    assign dy = (srt_a_rd[2*COORD_BITS-1:COORD_BITS] > srt_b_rd[2*COORD_BITS-1:COORD_BITS])
              ? srt_a_rd[2*COORD_BITS-1:COORD_BITS] - srt_b_rd[2*COORD_BITS-1:COORD_BITS]
              : srt_b_rd[2*COORD_BITS-1:COORD_BITS] - srt_a_rd[2*COORD_BITS-1:COORD_BITS];
    assign dsq  = DW'(dx) * DW'(dx) + DW'(dy) * DW'(dy);
    assign dsat = (XW'(dsq) >= XW'(RADIUS_INF)) ? RADIUS_INF - RADIUS_BITS'(1)
                                                : RADIUS_BITS'(dsq);
    assign r_upd = (st_reg == BK_RAD && j_reg != '0 && nb_p > own_p && dsat < r_reg)
                 ? dsat : r_reg;

    always_comb begin
        case (st_reg)
            BK_SORT: hit = (j_reg != '0) && ahead;
            BK_THR:  hit = (j_reg != '0) && (rad_b_rd >= rad_a_rd);
            default: hit = 1'b0;
        endcase
        cnt_add = cnt_reg + CW'(hit);
    end

    always_comb begin
        st_next = st_reg;
        n_next = n_reg;
        i_next = i_reg;
        j_next = j_reg;
        cnt_next = cnt_reg;
        r_next = r_reg;
        thr_next = thr_reg;
        tot_next = tot_reg;
        k_next = k_reg;
        small_next = small_reg;
        o_valid_next = o_valid_reg && !o_ready;
        o_data_next = o_data_reg;
        pt_we = 1'b0;
        srt_we = 1'b0;
        rad_we = 1'b0;
        case (st_reg)
            BK_IDLE: begin
                if (take) begin
                    // a point beyond the store is dropped
                    if (n_reg < MAXC) begin
                        pt_we = 1'b1;
                        n_next = n_reg + CW'(1);
                    end
                    if (q_last) begin
                        small_next = (7'(n_next) <= num_to_keep);
                        i_next = '0;
                        j_next = '0;
                        k_next = '0;
                        cnt_next = '0;
                        thr_next = '0;
                        r_next = RADIUS_INF;
                        st_next = small_next ? BK_EMIT : BK_SORT;
                    end
                end
            end
            BK_SORT: begin
                // rank of point i counted over all j, then written to its sorted slot
                if (j_reg == n_reg) begin
                    srt_we = 1'b1;
                    cnt_next = '0;
                    j_next = '0;
                    if (i_reg + CW'(1) == n_reg) begin
                        st_next = BK_RAD;
                        i_next = '0;
                        r_next = RADIUS_INF;
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                end else begin
                    cnt_next = cnt_add;
                    j_next = j_reg + CW'(1);
                end
            end
            BK_RAD: begin
                // one stronger candidate neighbour per cycle
                if (j_reg == i_reg) begin
                    rad_we = 1'b1;
                    j_next = '0;
                    r_next = RADIUS_INF;
                    if (i_reg + CW'(1) == n_reg) begin
                        st_next = BK_THR;
                        i_next = '0;
                        cnt_next = '0;
                        thr_next = '0;
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                end else begin
                    r_next = r_upd;
                    j_next = j_reg + CW'(1);
                end
            end
            BK_THR: begin
                // threshold is the largest radius with more than keep radii at or above it
                if (j_reg == n_reg) begin
                    if (7'(cnt_add) > num_to_keep && rad_a_rd >= thr_reg) begin
                        thr_next = rad_a_rd;
                        tot_next = cnt_add;
                    end
                    cnt_next = '0;
                    j_next = '0;
                    if (i_reg + CW'(1) == n_reg) begin
                        st_next = BK_EMIT;
                        i_next = '0;
                        k_next = '0;
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                end else begin
                    cnt_next = cnt_add;
                    j_next = j_reg + CW'(1);
                end
            end
            BK_EMIT: begin
                // j=0: read issued, j=1: data valid
                if (i_reg >= n_reg) begin
                    st_next = BK_IDLE;
                    n_next = '0;
                end else if (j_reg == '0) begin
                    j_next = CW'(1);
                end else if (!o_valid_reg || o_ready) begin
                    j_next = '0;
                    i_next = i_reg + CW'(1);
                    if (small_reg || rad_a_rd >= thr_reg) begin
                        o_valid_next = 1'b1;
                        k_next = k_reg + CW'(1);
                        o_data_next = {
                            (small_reg ? (i_reg + CW'(1) == n_reg) : (k_reg + CW'(1) == tot_reg)),
                            (small_reg ? RADIUS_BITS'(0) : rad_a_rd),
                            (small_reg ? pt_a_rd : srt_a_rd)};
                    end
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= BK_IDLE;
            n_reg <= '0;
            o_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            n_reg <= n_next;
            o_valid_reg <= o_valid_next;
        end
        i_reg <= i_next;
        j_reg <= j_next;
        cnt_reg <= cnt_next;
        r_reg <= r_next;
        thr_reg <= thr_next;
        tot_reg <= tot_next;
        k_reg <= k_next;
        small_reg <= small_next;
        o_data_reg <= o_data_next;
    end
endmodule

>>> sv/adaptive_non_maximal_suppression.sv
// top level of the adaptive non-maximal suppression block
//  channel | dir | ports                  | contents
//  points  | in  | s_axis_t*              | x, y, response; tlast ends a set
//  kept    | out | m_axis_t*              | x, y, response, radius_sq; tlast ends
//  config  | in  | cfg_we/cfg_addr/cfg_wdata | num_to_keep, robust_coeff
// points load at one item a cycle through a two-item queue while the sequencer is idle.
// on tlast a sequencer ranks the n points, searches radii, finds the threshold
// and emits the kept points one at a time, each read before it is sent; a set no
// larger than the target skips straight to emit.
// input stalls once the queue fills during selection; reset clears control only.
module adaptive_non_maximal_suppression #(
    parameter int MAX_POINTS    = 64,
    parameter int COORD_BITS    = 12,
    parameter int RESPONSE_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // x, y, response
    input  logic [((2*COORD_BITS+RESPONSE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tlast,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // out_x, out_y, out_response, radius_sq
    output logic [((2*COORD_BITS+RESPONSE_BITS+anms_pkg::RADIUS_BITS+7)/8)*8-1:0]
                 m_axis_tdata,
    output logic m_axis_tlast,
    input  logic cfg_we,
    input  logic [anms_pkg::CFG_IDX_BITS-1:0] cfg_addr,
    input  logic [8:0] cfg_wdata
);
    import anms_pkg::*;

    localparam int PW = 2*COORD_BITS + RESPONSE_BITS;
    localparam int QW = PW + 1;
    localparam int OW = PW + RADIUS_BITS + 1;
    localparam int MW = ((PW + RADIUS_BITS + 7)/8)*8;

    logic [6:0] keep_reg;
    logic [8:0] coeff_reg;
    logic q_valid, q_ready;
    logic [QW-1:0] q_data;
    logic [OW-1:0] o_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg  <= 7'd16;
            coeff_reg <= 9'd284;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_NUM_TO_KEEP:  keep_reg  <= cfg_wdata[6:0];
                REG_ROBUST_COEFF: coeff_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    anms_front #(.COORD_BITS(COORD_BITS), .RESPONSE_BITS(RESPONSE_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data({s_axis_tlast, s_axis_tdata[PW-1:0]}),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    anms_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS),
                .RESPONSE_BITS(RESPONSE_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .num_to_keep(keep_reg), .robust_coeff(coeff_reg),
        .o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_data(o_data)
    );

    assign m_axis_tdata = MW'(o_data[OW-2:0]);
    assign m_axis_tlast = o_data[OW-1];
endmodule

>>> sv/anms_checker.sv
// port checker for the anms block
`include "adaptive_non_maximal_suppression_macros.svh"
module anms_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast
);
    `ANMS_ASSERT_IMP(hold_valid, aclk, aresetn, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid)
    `ANMS_ASSERT_IMP(hold_last, aclk, aresetn, m_axis_tvalid && !m_axis_tready, ##1 $stable(m_axis_tlast))
    `ANMS_ASSERT_ALWAYS(no_x_valid, aclk, aresetn, !$isunknown(m_axis_tvalid))
endmodule

bind adaptive_non_maximal_suppression anms_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tlast(m_axis_tlast)
);
